@@ rtl/smx_pkg.sv @@
// ---------------------------------------------------------------------------
// smx_pkg
// Shared types, widths and the arctangent table of the stroke metrics block.
// ---------------------------------------------------------------------------
`default_nettype none

package smx_pkg;

   localparam int MAX_POINTS_DEF = 1024;
   localparam int COORD_W        = 20;
   localparam int TIME_W         = 32;
   localparam int LEN_W          = 32;
   localparam int ANG_W          = 16;
   localparam int FRAC_W         = 17;
   localparam logic [FRAC_W-1:0] FRAC_RESET = 17'd16384;

   // segment deltas and the square root datapath
   localparam int DW   = COORD_W + 1;
   localparam int SQ_W = 44;

   // vectoring rotator
   localparam int CORDIC_STEPS = 30;
   localparam int CORD_SH      = 30;
   localparam int CORD_W       = 54;
   localparam int ZW           = 34;
   localparam int ATAN_W       = 30;

   // mean speed: length * 16000 / duration
   localparam int PROD_W = 46;
   localparam int MULK_W = 14;
   localparam logic [MULK_W-1:0] SPEED_MUL = 14'd16000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQR,
      ST_SQSUM,
      ST_ROOT,
      ST_UPDATE,
      ST_PREP,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_CORD_LOAD,
      ST_CORD_STEP,
      ST_CORD_DONE,
      ST_DIV_INIT,
      ST_DIV,
      ST_LOAD
   } smx_state_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [LEN_W-1:0]          rl;
   } smx_entry_type;

   // binary-angle arctangent of 2^-i, 2^31 = pi
   function automatic logic [ATAN_W-1:0] atan_entry(input logic [4:0] i);
      logic [ATAN_W-1:0] r;
      case (i)
         5'd0:  r = 30'h20000000;
         5'd1:  r = 30'h12E4051E;
         5'd2:  r = 30'h09FB385B;
         5'd3:  r = 30'h051111D4;
         5'd4:  r = 30'h028B0D43;
         5'd5:  r = 30'h0145D7E1;
         5'd6:  r = 30'h00A2F61E;
         5'd7:  r = 30'h00517C55;
         5'd8:  r = 30'h0028BE53;
         5'd9:  r = 30'h00145F2F;
         5'd10: r = 30'h000A2F98;
         5'd11: r = 30'h000517CC;
         5'd12: r = 30'h00028BE6;
         5'd13: r = 30'h000145F3;
         5'd14: r = 30'h0000A2F9;
         5'd15: r = 30'h0000517C;
         5'd16: r = 30'h000028BE;
         5'd17: r = 30'h0000145F;
         5'd18: r = 30'h00000A2F;
         5'd19: r = 30'h00000517;
         5'd20: r = 30'h0000028B;
         5'd21: r = 30'h00000145;
         5'd22: r = 30'h000000A2;
         5'd23: r = 30'h00000051;
         5'd24: r = 30'h00000028;
         5'd25: r = 30'h00000014;
         5'd26: r = 30'h0000000A;
         5'd27: r = 30'h00000005;
         5'd28: r = 30'h00000002;
         5'd29: r = 30'h00000001;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/stroke_metrics_extractor_unit.sv @@
// ---------------------------------------------------------------------------
// stroke_metrics_extractor_unit
// Collects the pen points of a stroke and reports box, length, timing and
// angles when the last point arrives.
// ---------------------------------------------------------------------------
// Usage
//   req_* carries one pen point per item; req_last_point closes the stroke.
//   csr_wr_en/csr_wr_data set the entry fraction (Q1.16) while idle.
//   rsp_* carries one item per stroke, held in an output register.
// Sequence
//   The first point of a stroke goes straight to the update; every other
//   point first runs the bit-serial square root of the segment length
//   (22 steps). A last point then adds the entry search over the N stored
//   points, the two angle rotations of the shared 30-step rotator and the
//   bit-serial speed division. req_stall is high whenever a point is in
//   work.
// Reset
//   Synchronous reset empties the stroke and the output register and sets
//   the entry fraction to one quarter. The point memory needs no clearing.
// Stall
//   A result waits in the output register while rsp_stall is high; the
//   block keeps taking points and only holds a later result until the
//   register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module stroke_metrics_extractor_unit #(
   parameter int MAX_POINTS = smx_pkg::MAX_POINTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [smx_pkg::COORD_W-1:0] req_x_pos,
   input  logic signed [smx_pkg::COORD_W-1:0] req_y_pos,
   input  logic [smx_pkg::TIME_W-1:0]        req_time_stamp,
   input  logic                              req_last_point,
   input  logic                              csr_wr_en,
   input  logic [smx_pkg::FRAC_W-1:0]        csr_wr_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [smx_pkg::COORD_W-1:0] rsp_left_edge,
   output logic signed [smx_pkg::COORD_W-1:0] rsp_top_edge,
   output logic signed [smx_pkg::COORD_W-1:0] rsp_right_edge,
   output logic signed [smx_pkg::COORD_W-1:0] rsp_bottom_edge,
   output logic [smx_pkg::LEN_W-1:0]         rsp_path_length,
   output logic signed [smx_pkg::TIME_W-1:0] rsp_duration,
   output logic [smx_pkg::LEN_W-1:0]         rsp_mean_speed,
   output logic signed [smx_pkg::ANG_W-1:0]  rsp_chord_angle,
   output logic signed [smx_pkg::ANG_W-1:0]  rsp_entry_angle,
   output logic                              rsp_overflow
);
   import smx_pkg::*;

   localparam int AW  = $clog2(MAX_POINTS);
   localparam int CW  = $clog2(MAX_POINTS + 1);
   localparam int TGW = LEN_W + FRAC_W;

   smx_state_type state_ff, state_in;

   // control state
   logic [FRAC_W-1:0] frac_ff;
   logic [CW-1:0]     count_ff;
   logic [LEN_W-1:0]  len_ff;
   logic              ovf_ff;
   logic              rsp_valid_ff;
   logic              sel_ff;
   logic [4:0]        step_ff;
   logic [5:0]        div_cnt_ff;
   logic [CW-1:0]     idx_ff;

   // payload
   logic signed [COORD_W-1:0] x_ff, y_ff, first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic signed [COORD_W-1:0] left_ff, top_ff, right_ff, bottom_ff, ex_ff, ey_ff;
   logic [TIME_W-1:0]         t_ff, first_t_ff, dur_ff;
   logic                      last_ff;
   logic [2*DW-1:0]           sqx_ff, sqy_ff;
   logic [SQ_W-1:0]           sq_rem_ff, sq_res_ff, sq_bit_ff;
   logic [TGW-1:0]            target_ff;
   logic [PROD_W-1:0]         div_q_ff;
   logic [LEN_W-1:0]          div_rem_ff;
   logic signed [CORD_W-1:0]  cx_ff, cy_ff;
   logic signed [ZW-1:0]      cz_ff;
   logic                      zero_ff;
   logic [ANG_W-1:0]          chord_ff, entry_ff;
   smx_entry_type             rd_ff;

   logic signed [COORD_W-1:0] rsp_left_ff, rsp_top_ff, rsp_right_ff, rsp_bottom_ff;
   logic [LEN_W-1:0]          rsp_len_ff, rsp_speed_ff;
   logic [TIME_W-1:0]         rsp_dur_ff;
   logic [ANG_W-1:0]          rsp_chord_ff, rsp_entry_ff;
   logic                      rsp_ovf_ff;

   smx_entry_type mem [MAX_POINTS];

   // combinational helpers
   logic                  accept, out_take, load_fire, mem_we, mem_re;
   logic signed [DW-1:0]  dx, dy, lvx, lvy;
   logic signed [2*DW-1:0] sqx_w, sqy_w;
   logic [SQ_W-1:0]       trial;
   logic [LEN_W-1:0]      seg_w, len_new;
   logic [LEN_W:0]        len_sum;
   logic [TGW-1:0]        rl_scaled;
   logic signed [CORD_W-1:0] xs, ys;
   logic signed [ZW-1:0]  atan_z, z_round;
   logic [LEN_W:0]        div_sh;
   smx_entry_type         wr_entry;

   assign accept    = req_valid && !req_stall;
   assign out_take  = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // segment deltas and squares
   assign dx    = $signed({x_ff[COORD_W-1], x_ff}) - $signed({prev_x_ff[COORD_W-1], prev_x_ff});
   assign dy    = $signed({y_ff[COORD_W-1], y_ff}) - $signed({prev_y_ff[COORD_W-1], prev_y_ff});
   assign sqx_w = dx * dx;
   assign sqy_w = dy * dy;

   // square root trial value and rounded segment length
   assign trial   = sq_res_ff + sq_bit_ff;
   assign seg_w   = LEN_W'(sq_res_ff) + LEN_W'(sq_rem_ff > sq_res_ff);
   assign len_sum = {1'b0, len_ff} + {1'b0, seg_w};
   assign len_new = (count_ff == '0) ? '0 :
                    (len_sum[LEN_W] ? {LEN_W{1'b1}} : len_sum[LEN_W-1:0]);

   assign wr_entry.x  = x_ff;
   assign wr_entry.y  = y_ff;
   assign wr_entry.rl = len_new;

   // entry search compare operand
   assign rl_scaled = {1'b0, rd_ff.rl, 16'b0};

   // vector to be measured: chord first, entry second
   assign lvx = sel_ff ? ($signed({ex_ff[COORD_W-1], ex_ff}) -
                          $signed({first_x_ff[COORD_W-1], first_x_ff}))
                       : ($signed({x_ff[COORD_W-1], x_ff}) -
                          $signed({first_x_ff[COORD_W-1], first_x_ff}));
   assign lvy = sel_ff ? ($signed({ey_ff[COORD_W-1], ey_ff}) -
                          $signed({first_y_ff[COORD_W-1], first_y_ff}))
                       : ($signed({y_ff[COORD_W-1], y_ff}) -
                          $signed({first_y_ff[COORD_W-1], first_y_ff}));

   assign xs      = cx_ff >>> step_ff;
   assign ys      = cy_ff >>> step_ff;
   assign atan_z  = $signed({{(ZW-ATAN_W){1'b0}}, atan_entry(step_ff)});
   assign z_round = cz_ff + $signed(ZW'(32768));

   assign div_sh = {div_rem_ff, div_q_ff[PROD_W-1]};

   // next state and strobes
   always_comb begin
      state_in  = state_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      load_fire = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (count_ff == '0) ? ST_UPDATE : ST_SQR;
            end
         end
         ST_SQR:   state_in = ST_SQSUM;
         ST_SQSUM: state_in = ST_ROOT;
         ST_ROOT: begin
            if (sq_bit_ff == '0) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            mem_we   = (count_ff < CW'(MAX_POINTS));
            state_in = last_ff ? ST_PREP : ST_IDLE;
         end
         ST_PREP: state_in = ST_SRCH_RD;
         ST_SRCH_RD: begin
            if (idx_ff >= count_ff) begin
               state_in = ST_CORD_LOAD;
            end else begin
               mem_re   = 1'b1;
               state_in = ST_SRCH_CMP;
            end
         end
         ST_SRCH_CMP: begin
            state_in = (rl_scaled >= target_ff) ? ST_CORD_LOAD : ST_SRCH_RD;
         end
         ST_CORD_LOAD: state_in = ST_CORD_STEP;
         ST_CORD_STEP: begin
            if (step_ff == 5'(CORDIC_STEPS - 1)) begin
               state_in = ST_CORD_DONE;
            end
         end
         ST_CORD_DONE: state_in = sel_ff ? ST_DIV_INIT : ST_CORD_LOAD;
         ST_DIV_INIT: state_in = ($signed(dur_ff) > 0) ? ST_DIV : ST_LOAD;
         ST_DIV: begin
            if (div_cnt_ff == 6'(PROD_W - 1)) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_fire = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register and control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         frac_ff      <= FRAC_RESET;
         count_ff     <= '0;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
         step_ff      <= '0;
         div_cnt_ff   <= '0;
         idx_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            frac_ff <= csr_wr_data;
         end
         if (state_ff == ST_UPDATE) begin
            len_ff <= len_new;
            if (count_ff < CW'(MAX_POINTS)) begin
               count_ff <= count_ff + 1'b1;
            end else begin
               ovf_ff <= 1'b1;
            end
         end
         if (state_ff == ST_PREP) begin
            idx_ff <= CW'(1);
            sel_ff <= 1'b0;
         end
         if (state_ff == ST_SRCH_CMP && !(rl_scaled >= target_ff)) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (state_ff == ST_CORD_LOAD) begin
            step_ff <= '0;
         end
         if (state_ff == ST_CORD_STEP) begin
            step_ff <= step_ff + 1'b1;
         end
         if (state_ff == ST_CORD_DONE) begin
            sel_ff <= 1'b1;
         end
         if (state_ff == ST_DIV_INIT) begin
            div_cnt_ff <= '0;
         end
         if (state_ff == ST_DIV) begin
            div_cnt_ff <= div_cnt_ff + 1'b1;
         end
         // drop the stroke once its item is handed to the output register
         if (load_fire) begin
            count_ff <= '0;
            len_ff   <= '0;
            ovf_ff   <= 1'b0;
         end
         if (load_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // point memory: written once per stored point, read only during the search
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[AW-1:0]] <= wr_entry;
      end
      if (mem_re) begin
         rd_ff <= mem[idx_ff[AW-1:0]];
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff    <= req_x_pos;
         y_ff    <= req_y_pos;
         t_ff    <= req_time_stamp;
         last_ff <= req_last_point;
      end
      case (state_ff)
         ST_SQR: begin
            sqx_ff <= $unsigned(sqx_w);
            sqy_ff <= $unsigned(sqy_w);
         end
         ST_SQSUM: begin
            sq_rem_ff <= SQ_W'(sqx_ff) + SQ_W'(sqy_ff);
            sq_res_ff <= '0;
            sq_bit_ff <= SQ_W'(1) << (SQ_W - 2);
         end
         ST_ROOT: begin
            if (sq_bit_ff != '0) begin
               if (sq_rem_ff >= trial) begin
                  sq_rem_ff <= sq_rem_ff - trial;
                  sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
               end else begin
                  sq_res_ff <= sq_res_ff >> 1;
               end
               sq_bit_ff <= sq_bit_ff >> 2;
            end
         end
         ST_UPDATE: begin
            prev_x_ff <= x_ff;
            prev_y_ff <= y_ff;
            if (count_ff == '0) begin
               first_x_ff <= x_ff;
               first_y_ff <= y_ff;
               first_t_ff <= t_ff;
               dur_ff     <= '0;
               left_ff    <= x_ff;
               right_ff   <= x_ff;
               top_ff     <= y_ff;
               bottom_ff  <= y_ff;
            end else begin
               dur_ff <= t_ff - first_t_ff;
               if (x_ff < left_ff)   left_ff   <= x_ff;
               if (x_ff > right_ff)  right_ff  <= x_ff;
               if (y_ff < top_ff)    top_ff    <= y_ff;
               if (y_ff > bottom_ff) bottom_ff <= y_ff;
            end
         end
         ST_PREP: begin
            target_ff <= TGW'(len_ff) * TGW'(frac_ff);
            div_q_ff  <= PROD_W'(len_ff) * PROD_W'(SPEED_MUL);
            ex_ff     <= x_ff;
            ey_ff     <= y_ff;
         end
         ST_SRCH_CMP: begin
            if (rl_scaled >= target_ff) begin
               ex_ff <= rd_ff.x;
               ey_ff <= rd_ff.y;
            end
         end
         ST_CORD_LOAD: begin
            zero_ff <= (lvx == '0) && (lvy == '0);
            if (lvx < 0) begin
               if (lvy >= 0) begin
                  cx_ff <= CORD_W'(lvy) <<< CORD_SH;
                  cy_ff <= CORD_W'(-lvx) <<< CORD_SH;
                  cz_ff <= $signed(ZW'(1) << 30);
               end else begin
                  cx_ff <= CORD_W'(-lvy) <<< CORD_SH;
                  cy_ff <= CORD_W'(lvx) <<< CORD_SH;
                  cz_ff <= -$signed(ZW'(1) << 30);
               end
            end else begin
               cx_ff <= CORD_W'(lvx) <<< CORD_SH;
               cy_ff <= CORD_W'(lvy) <<< CORD_SH;
               cz_ff <= '0;
            end
         end
         ST_CORD_STEP: begin
            if (cy_ff >= 0) begin
               cx_ff <= cx_ff + ys;
               cy_ff <= cy_ff - xs;
               cz_ff <= cz_ff + atan_z;
            end else begin
               cx_ff <= cx_ff - ys;
               cy_ff <= cy_ff + xs;
               cz_ff <= cz_ff - atan_z;
            end
         end
         ST_CORD_DONE: begin
            if (!sel_ff) begin
               chord_ff <= zero_ff ? '0 : z_round[31:16];
            end else begin
               entry_ff <= zero_ff ? '0 : z_round[31:16];
            end
         end
         ST_DIV_INIT: begin
            div_rem_ff <= '0;
            if (!($signed(dur_ff) > 0)) begin
               div_q_ff <= '0;
            end
         end
         ST_DIV: begin
            if (div_sh >= {1'b0, dur_ff}) begin
               div_rem_ff <= LEN_W'(div_sh - {1'b0, dur_ff});
               div_q_ff   <= {div_q_ff[PROD_W-2:0], 1'b1};
            end else begin
               div_rem_ff <= div_sh[LEN_W-1:0];
               div_q_ff   <= {div_q_ff[PROD_W-2:0], 1'b0};
            end
         end
         default: begin
         end
      endcase
      // hand the finished stroke to the output register
      if (load_fire) begin
         rsp_left_ff   <= left_ff;
         rsp_top_ff    <= top_ff;
         rsp_right_ff  <= right_ff;
         rsp_bottom_ff <= bottom_ff;
         rsp_len_ff    <= len_ff;
         rsp_dur_ff    <= dur_ff;
         rsp_speed_ff  <= (div_q_ff[PROD_W-1:LEN_W] != '0) ? {LEN_W{1'b1}}
                                                           : div_q_ff[LEN_W-1:0];
         rsp_chord_ff  <= chord_ff;
         rsp_entry_ff  <= entry_ff;
         rsp_ovf_ff    <= ovf_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_edge   = rsp_left_ff;
   assign rsp_top_edge    = rsp_top_ff;
   assign rsp_right_edge  = rsp_right_ff;
   assign rsp_bottom_edge = rsp_bottom_ff;
   assign rsp_path_length = rsp_len_ff;
   assign rsp_duration    = $signed(rsp_dur_ff);
   assign rsp_mean_speed  = rsp_speed_ff;
   assign rsp_chord_angle = $signed(rsp_chord_ff);
   assign rsp_entry_angle = $signed(rsp_entry_ff);
   assign rsp_overflow    = rsp_ovf_ff;

endmodule

`default_nettype wire

@@ rtl/smx_checker.sv @@
// ---------------------------------------------------------------------------
// smx_checker
// Port-level checks of the stroke metrics block, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none

module smx_port_checks (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [smx_pkg::COORD_W-1:0] rsp_left_edge,
   input logic signed [smx_pkg::COORD_W-1:0] rsp_top_edge,
   input logic signed [smx_pkg::COORD_W-1:0] rsp_right_edge,
   input logic signed [smx_pkg::COORD_W-1:0] rsp_bottom_edge,
   input logic [smx_pkg::LEN_W-1:0]         rsp_path_length
);

   // a stalled item stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result item dropped while stalled");

   // a stalled item keeps its length
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_path_length))
      else $error("stalled result item changed");

   // every accepted point keeps the block busy in the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("point accepted without going busy");

   // the box is never inverted
   a_box: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_left_edge <= rsp_right_edge) && (rsp_top_edge <= rsp_bottom_edge))
      else $error("bounding box inverted");

   // reset empties the output register
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result item present after reset");

endmodule

bind stroke_metrics_extractor_unit smx_port_checks u_smx_port_checks (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_left_edge   (rsp_left_edge),
   .rsp_top_edge    (rsp_top_edge),
   .rsp_right_edge  (rsp_right_edge),
   .rsp_bottom_edge (rsp_bottom_edge),
   .rsp_path_length (rsp_path_length)
);

`default_nettype wire

@@ dv/smx_checker.sv @@
// ---------------------------------------------------------------------------
// smx_checker
// Watches the point, result and register ports of the stroke metrics block,
// predicts the summary of every closed stroke and compares each result item
// field by field with the oldest prediction still due.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module smx_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic signed [smx_pkg::COORD_W-1:0] req_x_pos,
   input  logic signed [smx_pkg::COORD_W-1:0] req_y_pos,
   input  logic [smx_pkg::TIME_W-1:0]         req_time_stamp,
   input  logic                               req_last_point,
   input  logic                               csr_wr_en,
   input  logic [smx_pkg::FRAC_W-1:0]         csr_wr_data,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic signed [smx_pkg::COORD_W-1:0] rsp_left_edge,
   input  logic signed [smx_pkg::COORD_W-1:0] rsp_top_edge,
   input  logic signed [smx_pkg::COORD_W-1:0] rsp_right_edge,
   input  logic signed [smx_pkg::COORD_W-1:0] rsp_bottom_edge,
   input  logic [smx_pkg::LEN_W-1:0]          rsp_path_length,
   input  logic signed [smx_pkg::TIME_W-1:0]  rsp_duration,
   input  logic [smx_pkg::LEN_W-1:0]          rsp_mean_speed,
   input  logic signed [smx_pkg::ANG_W-1:0]   rsp_chord_angle,
   input  logic signed [smx_pkg::ANG_W-1:0]   rsp_entry_angle,
   input  logic                               rsp_overflow,
   output int                                 errors,
   output int                                 awaiting
);

   localparam int DEPTH = smx_pkg::MAX_POINTS_DEF;

   typedef struct {
      logic [31:0] left, top, right, bottom;
      logic [31:0] length, dur, speed;
      logic [15:0] chord, entry;
      logic        spilled;
   } stroke_summary_type;

   // arctangent of 2^-i in binary angle units, 2^31 is a half turn
   localparam longint ARC [30] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
      64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
      64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001};

   stroke_summary_type summaries_due[$];

   logic [16:0] fraction;
   longint      keep_x [DEPTH];
   longint      keep_y [DEPTH];
   logic [31:0] keep_len [DEPTH];
   int          count;
   logic [31:0] run_len;
   longint      org_x, org_y, prev_x, prev_y;
   longint      lo_x, lo_y, hi_x, hi_y;
   logic [31:0] org_t;
   logic        spilled;

   // rounded square root of dx^2 + dy^2
   function automatic logic [31:0] segment_length(longint dx, longint dy);
      logic [63:0] v, rem, res, b;
      v   = dx * dx + dy * dy;
      rem = v;
      res = 0;
      b   = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (rem >= res + b) begin
            rem = rem - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      if (rem > res) res = res + 1;
      return res[31:0];
   endfunction

   // vectoring rotation, result rounded to a 16-bit binary angle
   function automatic logic [15:0] heading(longint dx, longint dy);
      longint x, y, z, xs, ys;
      if (dx == 0 && dy == 0) return 16'd0;
      if (dx < 0) begin
         if (dy >= 0) begin
            x = dy; y = -dx; z = 64'sd1 <<< 30;
         end else begin
            x = -dy; y = dx; z = -(64'sd1 <<< 30);
         end
      end else begin
         x = dx; y = dy; z = 0;
      end
      x = x * 64'sd1073741824;
      y = y * 64'sd1073741824;
      for (int i = 0; i < 30; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + ARC[i];
         end else begin
            x = x - ys; y = y + xs; z = z - ARC[i];
         end
      end
      z = (z + 32768) >>> 16;
      return z[15:0];
   endfunction

   // fold one accepted point into the stroke; close it on the last point
   task automatic absorb_point(longint x, longint y, logic [31:0] t, logic last);
      logic [63:0]        sum, target, speed;
      logic [31:0]        dur;
      longint             ex, ey;
      stroke_summary_type s;
      if (count == 0) begin
         org_x = x; org_y = y; org_t = t;
         lo_x = x; hi_x = x; lo_y = y; hi_y = y;
         run_len = 0;
      end else begin
         sum = 64'(run_len) + 64'(segment_length(x - prev_x, y - prev_y));
         run_len = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
         if (x < lo_x) lo_x = x;
         if (y < lo_y) lo_y = y;
         if (x > hi_x) hi_x = x;
         if (y > hi_y) hi_y = y;
      end
      if (count < DEPTH) begin
         keep_x[count] = x; keep_y[count] = y; keep_len[count] = run_len;
         count++;
      end else begin
         spilled = 1'b1;
      end
      prev_x = x; prev_y = y;
      if (!last) return;

      dur   = t - org_t;
      speed = 0;
      if ($signed(dur) > 0) begin
         speed = (64'(run_len) * 64'd16000) / 64'(dur);
         if (speed > 64'hFFFF_FFFF) speed = 64'hFFFF_FFFF;
      end
      ex = x; ey = y;
      target = 64'(run_len) * 64'(fraction);
      for (int i = 1; i < count; i++) begin
         if (64'(keep_len[i]) * 64'd65536 >= target) begin
            ex = keep_x[i]; ey = keep_y[i];
            break;
         end
      end
      s.left = 32'(lo_x); s.top = 32'(lo_y); s.right = 32'(hi_x); s.bottom = 32'(hi_y);
      s.length  = run_len;
      s.dur     = dur;
      s.speed   = speed[31:0];
      s.chord   = heading(x - org_x, y - org_y);
      s.entry   = heading(ex - org_x, ey - org_y);
      s.spilled = spilled;
      summaries_due.push_back(s);
      count = 0; run_len = 0; spilled = 1'b0;
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         if (errors < 10)
            $display("%t mismatch on %s: expected %h, got %h", $realtime, name, want, got);
         errors++;
      end
   endtask

   // sample on the rising edge: register writes, result items, then points
   always @(posedge clock) begin
      stroke_summary_type w;
      if (reset) begin
         fraction = smx_pkg::FRAC_RESET;
         count = 0; run_len = 0; spilled = 1'b0;
         prev_x = 0; prev_y = 0;
         summaries_due.delete();
      end else begin
         if (csr_wr_en) fraction = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            if (summaries_due.size() == 0) begin
               if (errors < 10) $display("%t result item with none due", $realtime);
               errors++;
            end else begin
               w = summaries_due.pop_front();
               check_field("left_edge",   w.left,   32'(rsp_left_edge));
               check_field("top_edge",    w.top,    32'(rsp_top_edge));
               check_field("right_edge",  w.right,  32'(rsp_right_edge));
               check_field("bottom_edge", w.bottom, 32'(rsp_bottom_edge));
               check_field("path_length", w.length, rsp_path_length);
               check_field("duration",    w.dur,    rsp_duration);
               check_field("mean_speed",  w.speed,  rsp_mean_speed);
               check_field("chord_angle", {16'd0, w.chord}, {16'd0, rsp_chord_angle});
               check_field("entry_angle", {16'd0, w.entry}, {16'd0, rsp_entry_angle});
               check_field("overflow",    32'(w.spilled), 32'(rsp_overflow));
            end
         end
         if (req_valid && !req_stall)
            absorb_point(req_x_pos, req_y_pos, req_time_stamp, req_last_point);
      end
      awaiting <= summaries_due.size();
   end

   initial errors = 0;

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Stroke stimulus for the stroke metrics block: a directed set of corner
// strokes, then random strokes under several entry fractions, with random
// idling on both channels. Checking is done by smx_checker.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module testbench;

   localparam int POINT_BUDGET = 900;
   localparam int CALM_TAIL    = 150;
   localparam int ZIGZAG_LEN   = 1030;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [19:0] req_x_pos = '0;
   logic signed [19:0] req_y_pos = '0;
   logic [31:0] req_time_stamp = '0;
   logic req_last_point = 1'b0;
   logic csr_wr_en = 1'b0;
   logic [16:0] csr_wr_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [19:0] rsp_left_edge, rsp_top_edge, rsp_right_edge, rsp_bottom_edge;
   logic [31:0] rsp_path_length, rsp_mean_speed;
   logic signed [31:0] rsp_duration;
   logic signed [15:0] rsp_chord_angle, rsp_entry_angle;
   logic rsp_overflow;
   int   errors, awaiting;

   logic        calm = 1'b0;
   int          points_sent = 0, strokes_sent = 0, hold_left = 0;
   logic signed [19:0] pen_x = '0, pen_y = '0;
   logic [31:0] pen_t = '0;

   always #5 clock = ~clock;

   stroke_metrics_extractor_unit dut (.*);

   smx_checker u_checker (.*);

   // result side: random stall bursts, none when calm
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_stall <= 1'b1;
         hold_left <= $urandom_range(0, 4);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // offer one point and hold it until it is taken
   task automatic send_point(logic signed [19:0] x, logic signed [19:0] y,
                             logic [31:0] t, logic last);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_x_pos      <= x;
      req_y_pos      <= y;
      req_time_stamp <= t;
      req_last_point <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pen_x = x; pen_y = y; pen_t = t;
      points_sent++;
      if (last) strokes_sent++;
   endtask

   // drop valid and hold off until every due summary has come back
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_fraction(logic [16:0] v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic signed [19:0] nudge(logic signed [19:0] p, int d);
      longint v;
      v = longint'(p) + d;
      if (v > 524287) v = 524287;
      if (v < -524288) v = -524288;
      return v[19:0];
   endfunction

   // one random stroke: mostly a pen walk, sometimes scattered points
   task automatic random_stroke;
      int   n, step;
      logic wide;
      n    = ($urandom_range(0, 6) == 0) ? 1 :
             ($urandom_range(0, 6) == 0) ? $urandom_range(11, 40) : $urandom_range(2, 10);
      wide = ($urandom_range(0, 4) == 0);
      step = ($urandom_range(0, 1) == 0) ? 200 : 20000;
      if (!wide) begin
         pen_x = 20'($urandom);
         pen_y = 20'($urandom);
      end
      for (int i = 0; i < n; i++) begin
         if (points_sent > POINT_BUDGET - CALM_TAIL) calm = 1'b1;
         send_point(wide ? 20'($urandom) : nudge(pen_x, $urandom_range(0, 2 * step) - step),
                    wide ? 20'($urandom) : nudge(pen_y, $urandom_range(0, 2 * step) - step),
                    ($urandom_range(0, 9) == 0) ? $urandom : pen_t + $urandom_range(0, 400),
                    i == n - 1);
      end
   endtask

   initial begin
      logic [16:0] settings [8];
      settings = '{17'd0, 17'd65536, 17'd65535, 17'd1, 17'd16384, 17'd0, 17'd0, 17'd0};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner strokes under the reset fraction
      send_point(-20'sd524288, 20'sd524287, 32'd0, 1'b1);
      send_point(-20'sd524288, -20'sd524288, 32'hFFFF_FFF0, 1'b0);
      send_point(20'sd524287, 20'sd524287, 32'h0000_0010, 1'b1);
      // closed loop: chord of zero length
      send_point(20'sd100, 20'sd100, 32'd1000, 1'b0);
      send_point(20'sd300, -20'sd50, 32'd1010, 1'b0);
      send_point(20'sd100, 20'sd100, 32'd1020, 1'b1);
      // heading of a half turn, time running backwards
      send_point(20'sd0, 20'sd0, 32'd500, 1'b0);
      send_point(-20'sd160, 20'sd0, 32'd400, 1'b1);
      // zero duration
      send_point(20'sd5, 20'sd5, 32'd7, 1'b0);
      send_point(20'sd5, 20'sd9, 32'd7, 1'b1);
      // lower left quadrant
      send_point(20'sd10, 20'sd10, 32'd50, 1'b0);
      send_point(-20'sd20, -20'sd40, 32'd60, 1'b0);
      send_point(-20'sd30, -20'sd80, 32'd70, 1'b1);
      // pen never moves
      send_point(20'sd77, -20'sd3, 32'd90, 1'b0);
      send_point(20'sd77, -20'sd3, 32'd95, 1'b0);
      send_point(20'sd77, -20'sd3, 32'd99, 1'b1);

      // random strokes, one fraction setting per phase
      for (int ph = 0; ph < 8; ph++) begin
         write_fraction(ph >= 5 ? 17'($urandom_range(0, 65536)) : settings[ph]);
         if (ph == 2) begin
            // zigzag between corners: spills the point store
            for (int i = 0; i < ZIGZAG_LEN; i++)
               send_point(i[0] ? 20'sd524287 : -20'sd524288,
                          i[0] ? 20'sd524287 : -20'sd524288,
                          32'(i * 3), i == ZIGZAG_LEN - 1);
            points_sent -= ZIGZAG_LEN;
         end
         while (points_sent < (ph + 1) * POINT_BUDGET / 8) random_stroke();
      end

      drain();
      repeat (300) @(posedge clock);
      $display("Covered %0d strokes from %0d random and corner points, plus one",
               strokes_sent, points_sent);
      $display("overlong stroke; entry fraction swept from zero to one.");
      if (errors == 0 && awaiting == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
